### rtl/dssa_pkg.sv
// shared types, constants and helpers for the dual stack block
package dssa_pkg;

  localparam int TOTAL_DEPTH = 16;
  localparam int HALF        = TOTAL_DEPTH / 2;
  localparam int MAX_RESULTS = 8;
  localparam int AW          = $clog2(TOTAL_DEPTH);
  localparam int CW          = $clog2(HALF + 1);
  localparam int LW          = (HALF > 1) ? $clog2(HALF) : 1;
  localparam int DW          = 32;

  typedef enum logic [2:0] {
    REQ_PUSH = 3'd0,
    REQ_POP  = 3'd1,
    REQ_PEEK = 3'd2,
    REQ_DUMP = 3'd3,
    REQ_REV  = 3'd4
  } req_t;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PEEK,
    S_DUMP_RD,
    S_DUMP_OUT,
    S_REV_RDLO,
    S_REV_RDHI,
    S_REV_WRLO,
    S_REV_WRHI,
    S_RESP
  } state_t;

  typedef struct packed {
    logic                 en;
    logic [AW-1:0]        addr;
    logic signed [DW-1:0] data;
  } mem_wr_t;

  // lower stack starts at entry zero, upper stack at the midpoint
  function automatic logic [AW-1:0] stk_addr(input logic sel, input logic [LW-1:0] off);
    logic [AW-1:0] base;
    base = sel ? AW'(HALF) : '0;
    return base + AW'(off);
  endfunction

endpackage

### rtl/dssa_store.sv
// element store: one write port and one registered read port
module dssa_store
  import dssa_pkg::*;
(
  input  logic                 clk,
  input  mem_wr_t              wr,
  input  logic [AW-1:0]        rd_addr,
  output logic signed [DW-1:0] rd_data
);

  logic signed [DW-1:0] mem [TOTAL_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### rtl/dual_stack_shared_array_top.sv
// top level of the two-stacks-in-one-array block
// Two LIFO stacks of 8 entries each share one 16-entry store; the lower stack
// occupies entries 0-7 and the upper stack entries 8-15. One transaction is
// taken at a time and in_stall stays high until its work is done. Push and pop
// go straight to the response; a peek first reads the top entry, a read-out
// reads and emits one entry at a time, and reverse swaps pairs from both ends.
// A peek or read-out of an empty stack goes straight to the response, and a stall
// on the result side holds the transaction back. The store has a single read
// port, so every swap step reads or writes one entry per cycle.
// A finished result sits in the output register while the next transaction is
// accepted. Request codes five to seven are dropped without a result.
module dual_stack_shared_array_top
  import dssa_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [2:0]           in_req_type,
  input  logic                 in_stack_sel,
  input  logic signed [DW-1:0] in_push_value,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           out_status,
  output logic signed [DW-1:0] out_element,
  output logic                 out_last
);

  state_t               state_r, state_nxt;
  logic [CW-1:0]        lower_cnt_r, lower_cnt_nxt;
  logic [CW-1:0]        upper_cnt_r, upper_cnt_nxt;
  logic                 sel_r, sel_nxt;
  logic [LW-1:0]        lo_r, lo_nxt;
  logic [LW-1:0]        hi_r, hi_nxt;
  logic [CW-1:0]        n_r, n_nxt;
  logic signed [DW-1:0] tmp_r, tmp_nxt;
  logic [1:0]           res_status_r, res_status_nxt;
  logic signed [DW-1:0] res_elem_r, res_elem_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [1:0]           out_status_r, out_status_nxt;
  logic signed [DW-1:0] out_element_r, out_element_nxt;
  logic                 out_last_r, out_last_nxt;

  mem_wr_t              wr;
  logic [AW-1:0]        rd_addr;
  logic signed [DW-1:0] rd_data;
  logic [CW-1:0]        cur_c;
  logic                 out_free;
  logic                 dump_last;

  dssa_store u_store (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_stall    = (state_r != S_IDLE);
  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_element = out_element_r;
  assign out_last    = out_last_r;

  assign cur_c     = in_stack_sel ? upper_cnt_r : lower_cnt_r;
  assign out_free  = !out_valid_r || !out_stall;
  assign dump_last = ((CW'(lo_r) + CW'(1)) == n_r);

  always_comb begin
    state_nxt       = state_r;
    lower_cnt_nxt   = lower_cnt_r;
    upper_cnt_nxt   = upper_cnt_r;
    sel_nxt         = sel_r;
    lo_nxt          = lo_r;
    hi_nxt          = hi_r;
    n_nxt           = n_r;
    tmp_nxt         = tmp_r;
    res_status_nxt  = res_status_r;
    res_elem_nxt    = res_elem_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_status_nxt  = out_status_r;
    out_element_nxt = out_element_r;
    out_last_nxt    = out_last_r;
    wr              = '0;
    rd_addr         = stk_addr(sel_r, lo_r);

    unique case (state_r)
      S_IDLE: begin
        // top entry is fetched right away in case this is a peek
        rd_addr = stk_addr(in_stack_sel, LW'(cur_c - CW'(1)));
        if (in_valid) begin
          sel_nxt        = in_stack_sel;
          res_status_nxt = ST_OK;
          res_elem_nxt   = '0;
          unique case (in_req_type)
            REQ_PUSH: begin
              state_nxt = S_RESP;
              if (cur_c == CW'(HALF)) begin
                res_status_nxt = ST_OVERFLOW;
              end else begin
                wr.en   = 1'b1;
                wr.addr = stk_addr(in_stack_sel, LW'(cur_c));
                wr.data = in_push_value;
                if (in_stack_sel) upper_cnt_nxt = cur_c + CW'(1);
                else              lower_cnt_nxt = cur_c + CW'(1);
              end
            end
            REQ_POP: begin
              state_nxt = S_RESP;
              if (cur_c == '0) begin
                res_status_nxt = ST_EMPTY;
              end else begin
                if (in_stack_sel) upper_cnt_nxt = cur_c - CW'(1);
                else              lower_cnt_nxt = cur_c - CW'(1);
              end
            end
            REQ_PEEK: begin
              if (cur_c == '0) begin
                res_status_nxt = ST_EMPTY;
                state_nxt      = S_RESP;
              end else begin
                state_nxt = S_PEEK;
              end
            end
            REQ_DUMP: begin
              if (cur_c == '0) begin
                res_status_nxt = ST_EMPTY;
                state_nxt      = S_RESP;
              end else begin
                lo_nxt    = '0;
                n_nxt     = (int'(cur_c) < MAX_RESULTS) ? cur_c : CW'(MAX_RESULTS);
                state_nxt = S_DUMP_RD;
              end
            end
            REQ_REV: begin
              if (cur_c > CW'(1)) begin
                lo_nxt    = '0;
                hi_nxt    = LW'(cur_c - CW'(1));
                state_nxt = S_REV_RDLO;
              end else begin
                state_nxt = S_RESP;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_PEEK: begin
        res_elem_nxt = rd_data;
        state_nxt    = S_RESP;
      end
      S_DUMP_RD: begin
        state_nxt = S_DUMP_OUT;
      end
      S_DUMP_OUT: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = ST_OK;
          out_element_nxt = rd_data;
          out_last_nxt    = dump_last;
          if (dump_last) begin
            state_nxt = S_IDLE;
          end else begin
            lo_nxt    = lo_r + LW'(1);
            state_nxt = S_DUMP_RD;
          end
        end
      end
      S_REV_RDLO: begin
        state_nxt = S_REV_RDHI;
      end
      S_REV_RDHI: begin
        rd_addr   = stk_addr(sel_r, hi_r);
        tmp_nxt   = rd_data;
        state_nxt = S_REV_WRLO;
      end
      S_REV_WRLO: begin
        wr.en     = 1'b1;
        wr.addr   = stk_addr(sel_r, lo_r);
        wr.data   = rd_data;
        state_nxt = S_REV_WRHI;
      end
      S_REV_WRHI: begin
        wr.en   = 1'b1;
        wr.addr = stk_addr(sel_r, hi_r);
        wr.data = tmp_r;
        lo_nxt  = lo_r + LW'(1);
        hi_nxt  = hi_r - LW'(1);
        if ((lo_r + LW'(1)) < (hi_r - LW'(1))) state_nxt = S_REV_RDLO;
        else                                   state_nxt = S_RESP;
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = res_status_r;
          out_element_nxt = res_elem_r;
          out_last_nxt    = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      lower_cnt_r <= '0;
      upper_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      lower_cnt_r <= lower_cnt_nxt;
      upper_cnt_r <= upper_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sel_r         <= sel_nxt;
    lo_r          <= lo_nxt;
    hi_r          <= hi_nxt;
    n_r           <= n_nxt;
    tmp_r         <= tmp_nxt;
    res_status_r  <= res_status_nxt;
    res_elem_r    <= res_elem_nxt;
    out_status_r  <= out_status_nxt;
    out_element_r <= out_element_nxt;
    out_last_r    <= out_last_nxt;
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (lower_cnt_r <= CW'(HALF)) && (upper_cnt_r <= CW'(HALF)))
    else $error("stack count beyond half depth");

  a_push_inc: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_req_type == REQ_PUSH) && !in_stack_sel &&
     (lower_cnt_r != CW'(HALF))) |=> (lower_cnt_r == $past(lower_cnt_r) + CW'(1)))
    else $error("push did not grow the lower stack");

  a_rev_order: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_REV_RDLO) || (state_r == S_REV_RDHI) ||
     (state_r == S_REV_WRLO) || (state_r == S_REV_WRHI)) |-> (lo_r < hi_r))
    else $error("reverse indices crossed");

  a_dump_idx: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_DUMP_RD) || (state_r == S_DUMP_OUT)) |-> (CW'(lo_r) < n_r))
    else $error("read-out index past entry count");

  a_busy_counts: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r != S_IDLE) && (state_r != S_RESP)) |=>
      ($stable(lower_cnt_r) && $stable(upper_cnt_r)))
    else $error("stack count changed during a multi-cycle transaction");
`endif

endmodule

### verif/dssa_checker.sv
// checker for the dual stack block: shadow stacks, expected results and comparison
`timescale 1ns / 1ps

module dssa_checker
  import dssa_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [2:0]           in_req_type,
  input  logic                 in_stack_sel,
  input  logic signed [DW-1:0] in_push_value,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [1:0]           out_status,
  input  logic signed [DW-1:0] out_element,
  input  logic                 out_last,
  output int                   fail_count,
  output int                   pending
);

  typedef struct {
    logic [1:0]           status;
    logic signed [DW-1:0] element;
    logic                 last;
  } stack_result_t;

  stack_result_t        result_q[$];
  logic signed [DW-1:0] shadow_mem [TOTAL_DEPTH];
  int                   lower_cnt;
  int                   upper_cnt;

  initial begin
    fail_count = 0;
    pending    = 0;
    lower_cnt  = 0;
    upper_cnt  = 0;
  end

  function automatic void queue_result(input logic [1:0] status,
                                       input logic signed [DW-1:0] element,
                                       input logic last);
    stack_result_t r;
    r.status  = status;
    r.element = element;
    r.last    = last;
    result_q.push_back(r);
  endfunction

  function automatic void flag_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%0t mismatch: %s", $realtime, msg);
    end
  endfunction

  // apply one request to the shadow stacks and queue what it should produce
  task automatic model_request(input logic [2:0] code, input logic sel,
                               input logic signed [DW-1:0] val);
    int                   cnt;
    int                   base;
    int                   n;
    int                   lo;
    int                   hi;
    logic signed [DW-1:0] tmp;
    cnt  = sel ? upper_cnt : lower_cnt;
    base = sel ? HALF : 0;
    if (cnt > HALF) cnt = HALF;
    case (req_t'(code))
      REQ_PUSH: begin
        if (cnt >= HALF) begin
          queue_result(ST_OVERFLOW, '0, 1'b1);
        end else begin
          shadow_mem[base + cnt] = val;
          cnt++;
          queue_result(ST_OK, '0, 1'b1);
        end
      end
      REQ_POP: begin
        if (cnt == 0) begin
          queue_result(ST_EMPTY, '0, 1'b1);
        end else begin
          cnt--;
          queue_result(ST_OK, '0, 1'b1);
        end
      end
      REQ_PEEK: begin
        if (cnt == 0) queue_result(ST_EMPTY, '0, 1'b1);
        else queue_result(ST_OK, shadow_mem[base + cnt - 1], 1'b1);
      end
      REQ_DUMP: begin
        if (cnt == 0) begin
          queue_result(ST_EMPTY, '0, 1'b1);
        end else begin
          n = (cnt < MAX_RESULTS) ? cnt : MAX_RESULTS;
          for (int j = 0; j < n; j++) begin
            queue_result(ST_OK, shadow_mem[base + j], (j == n - 1));
          end
        end
      end
      REQ_REV: begin
        lo = 0;
        hi = cnt - 1;
        while (lo < hi) begin
          tmp                  = shadow_mem[base + lo];
          shadow_mem[base + lo] = shadow_mem[base + hi];
          shadow_mem[base + hi] = tmp;
          lo++;
          hi--;
        end
        queue_result(ST_OK, '0, 1'b1);
      end
      default: ; // codes five to seven are dropped
    endcase
    if (sel) upper_cnt = cnt;
    else lower_cnt = cnt;
  endtask

  always @(posedge clk) begin
    stack_result_t want;
    if (!rst_n) begin
      result_q.delete();
      lower_cnt = 0;
      upper_cnt = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (result_q.size() == 0) begin
          flag_failure($sformatf("unexpected result status=%0d element=%0d last=%0b",
                                 out_status, out_element, out_last));
        end else begin
          want = result_q.pop_front();
          if (out_status !== want.status || out_element !== want.element ||
              out_last !== want.last) begin
            flag_failure($sformatf(
              "expected status=%0d element=%0d last=%0b, got status=%0d element=%0d last=%0b",
              want.status, want.element, want.last, out_status, out_element, out_last));
          end
        end
      end
      if (in_valid && !in_stall) begin
        model_request(in_req_type, in_stack_sel, in_push_value);
      end
    end
    pending = result_q.size();
  end

endmodule

### verif/tb_dual_stack_shared_array_top.sv
// testbench top for the dual stack block: stimulus, flow control and verdict
`timescale 1ns / 1ps

module tb_dual_stack_shared_array_top;
  import dssa_pkg::*;

  localparam int RANDOM_ITEMS = 420;
  localparam int HOLD_CYCLES  = 160;
  localparam int STUCK_LIMIT  = 3000;
  localparam int DRAIN_CYCLES = 40;

  // request codes with no meaning, the block drops them
  localparam logic [2:0] REQ_UNUSED_LO = 3'd5;
  localparam logic [2:0] REQ_UNUSED_HI = 3'd7;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [2:0]           in_req_type;
  logic                 in_stack_sel;
  logic signed [DW-1:0] in_push_value;
  logic                 out_valid;
  logic                 out_stall;
  logic [1:0]           out_status;
  logic signed [DW-1:0] out_element;
  logic                 out_last;

  int fail_count;
  int pending;
  int stuck_cycles;
  bit quiet;
  bit hold_go;
  bit holding;

  dual_stack_shared_array_top dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_req_type   (in_req_type),
    .in_stack_sel  (in_stack_sel),
    .in_push_value (in_push_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_status    (out_status),
    .out_element   (out_element),
    .out_last      (out_last)
  );

  dssa_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_req_type   (in_req_type),
    .in_stack_sel  (in_stack_sel),
    .in_push_value (in_push_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_status    (out_status),
    .out_element   (out_element),
    .out_last      (out_last),
    .fail_count    (fail_count),
    .pending       (pending)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver: random stalls, none in the quiet stretch, solid during a hold-off
  initial out_stall = 1'b0;
  always @(negedge clk) begin
    out_stall <= holding || (!quiet && ($urandom_range(99) < 6));
  end

  // long hold-off on the result side, counted here
  initial begin
    wait (hold_go);
    @(posedge clk);
    holding = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    holding = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  function automatic logic signed [DW-1:0] pick_value();
    case ($urandom_range(15))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return '0;
      3:       return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  // offer one transaction, entered and left at a falling edge
  task automatic send_request(input logic [2:0] code, input logic sel,
                              input logic signed [DW-1:0] val);
    if (!quiet && ($urandom_range(99) < 6)) begin
      in_valid      <= 1'b0;
      in_push_value <= $urandom;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_req_type   <= code;
    in_stack_sel  <= sel;
    in_push_value <= val;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  initial begin
    int          sent;
    int          r;
    bit          filling;
    logic [2:0]  code;
    stuck_cycles  = 0;
    in_valid      = 1'b0;
    in_req_type   = REQ_PUSH;
    in_stack_sel  = 1'b0;
    in_push_value = '0;
    rst_n         = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty lower stack corner cases
    send_request(REQ_POP,  1'b0, '0);
    send_request(REQ_PEEK, 1'b0, '0);
    send_request(REQ_DUMP, 1'b0, '0);
    send_request(REQ_REV,  1'b0, '0);
    // single entry, then a few
    send_request(REQ_PUSH, 1'b0, 32'sh8000_0000);
    send_request(REQ_REV,  1'b0, '0);
    send_request(REQ_PEEK, 1'b0, '0);
    send_request(REQ_PUSH, 1'b0, 32'sh7fff_ffff);
    send_request(REQ_PUSH, 1'b0, -32'sd1);
    send_request(REQ_REV,  1'b0, '0);
    send_request(REQ_DUMP, 1'b0, '0);
    send_request(REQ_UNUSED_LO, 1'b1, $urandom);
    send_request(REQ_UNUSED_HI, 1'b0, $urandom);
    // fill the upper stack past its end
    for (int i = 0; i < HALF; i++) send_request(REQ_PUSH, 1'b1, pick_value());
    send_request(REQ_PUSH, 1'b1, $urandom);
    send_request(REQ_DUMP, 1'b1, '0);
    send_request(REQ_REV,  1'b1, '0);
    send_request(REQ_DUMP, 1'b1, '0);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent == 100 && !hold_go) hold_go <= 1'b1;
      if (sent == 250) begin
        in_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        sent++;
        continue;
      end
      if (sent == 300) quiet <= 1'b1;
      if (sent == 380) quiet <= 1'b0;
      // alternate between growing and draining so both ends of each stack get hit
      filling = ((sent / 50) % 2) == 0;
      r = $urandom_range(99);
      if (r < (filling ? 55 : 20))      code = REQ_PUSH;
      else if (r < (filling ? 70 : 60)) code = REQ_POP;
      else if (r < (filling ? 80 : 72)) code = REQ_PEEK;
      else if (r < (filling ? 88 : 84)) code = REQ_DUMP;
      else if (r < (filling ? 96 : 95)) code = REQ_REV;
      else code = 3'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI));
      send_request(code, 1'($urandom_range(1)), pick_value());
      if (code <= REQ_REV) sent++;
    end
    in_valid <= 1'b0;

    do @(negedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
